[hdl/thoc_pkg.sv]
`timescale 1ns / 1ps

package thoc_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned TargetW = 11;
  localparam int unsigned BandW   = 8;
  localparam int unsigned OffsetW = 8;
  localparam int unsigned CalcW   = 13;
  localparam int unsigned CodeW   = 3;
  localparam int unsigned ToneW   = 3;
  localparam int unsigned PatW    = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  localparam logic [TargetW-1:0] TargetRst = 11'd480;
  localparam logic [BandW-1:0]   BandRst   = 8'd32;
  localparam logic [OffsetW-1:0] OffsetRst = 8'd80;

  localparam logic [CfgIdxW-1:0] CFG_TARGET = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BAND   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET = 2'd2;

  localparam logic [CodeW-1:0] CODE_IDLE     = 3'd0;
  localparam logic [CodeW-1:0] CODE_HEATING  = 3'd1;
  localparam logic [CodeW-1:0] CODE_READY    = 3'd2;
  localparam logic [CodeW-1:0] CODE_DONE     = 3'd3;
  localparam logic [CodeW-1:0] CODE_SHUTDOWN = 3'd4;

  localparam logic [ToneW-1:0] TONE_NONE  = 3'd0;
  localparam logic [ToneW-1:0] TONE_STOP  = 3'd1;
  localparam logic [ToneW-1:0] TONE_READY = 3'd2;
  localparam logic [ToneW-1:0] TONE_DONE  = 3'd3;
  localparam logic [ToneW-1:0] TONE_ALARM = 3'd4;

  // bit0 heater, bit1 red, bit2 green, bit3 blue
  localparam logic [PatW-1:0] PAT_OFF    = 4'b0000;
  localparam logic [PatW-1:0] PAT_HEATER = 4'b0001;
  localparam logic [PatW-1:0] PAT_RED    = 4'b0010;
  localparam logic [PatW-1:0] PAT_GREEN  = 4'b0100;
  localparam logic [PatW-1:0] PAT_BLUE   = 4'b1000;

  typedef enum logic [4:0] {
    MODE_IDLE     = 5'b00001,
    MODE_HEATING  = 5'b00010,
    MODE_READY    = 5'b00100,
    MODE_DONE     = 5'b01000,
    MODE_SHUTDOWN = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [CodeW-1:0] ctrl_state;
    logic             heater_on;
    logic             led_red;
    logic             led_green;
    logic             led_blue;
    logic [ToneW-1:0] tone_cmd;
    logic             heater_enabled;
  } result_t;

  typedef struct packed {
    logic [TargetW-1:0] target_temp;
    logic [BandW-1:0]   hysteresis_band;
    logic [OffsetW-1:0] overheat_offset;
  } cfg_t;

  function automatic logic [CodeW-1:0] mode_code(mode_t m);
    logic [CodeW-1:0] c;
    case (m)
      MODE_IDLE:     c = CODE_IDLE;
      MODE_HEATING:  c = CODE_HEATING;
      MODE_READY:    c = CODE_READY;
      MODE_DONE:     c = CODE_DONE;
      MODE_SHUTDOWN: c = CODE_SHUTDOWN;
      default:       c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

[hdl/thoc_core.sv]
`timescale 1ns / 1ps

module thoc_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_en,
  input  logic [thoc_pkg::SampleW-1:0]   sample,
  input  thoc_pkg::cfg_t                 cfg,
  output thoc_pkg::result_t              res
);

  thoc_pkg::mode_t               mode_r, mode_nxt;
  logic                          latch_r, latch_nxt;
  logic                          beep_r, beep_nxt;
  logic [thoc_pkg::PatW-1:0]     pat_r, pat_nxt;
  logic [thoc_pkg::ToneW-1:0]    tone;

  logic signed [thoc_pkg::CalcW-1:0] temp_s, tgt_s, thresh_s, low_s;
  logic                              above_thr, at_tgt, below_low;

  assign temp_s   = $signed({sample[thoc_pkg::SampleW-1], sample});
  assign tgt_s    = $signed({2'b00, cfg.target_temp});
  assign thresh_s = tgt_s + $signed({5'b00000, cfg.overheat_offset});
  assign low_s    = tgt_s - $signed({5'b00000, cfg.hysteresis_band});

  assign above_thr = temp_s > thresh_s;
  assign at_tgt    = temp_s >= tgt_s;
  assign below_low = temp_s < low_s;

  always_comb begin
    thoc_pkg::mode_t cls;
    mode_nxt  = mode_r;
    latch_nxt = latch_r;
    beep_nxt  = beep_r;
    pat_nxt   = pat_r;
    tone      = thoc_pkg::TONE_NONE;
    cls       = thoc_pkg::MODE_HEATING;
    if (mode_r == thoc_pkg::MODE_SHUTDOWN && !latch_r) begin
      // hold
    end else if (above_thr && !latch_r) begin
      mode_nxt  = thoc_pkg::MODE_SHUTDOWN;
      pat_nxt   = thoc_pkg::PAT_BLUE;
      tone      = thoc_pkg::TONE_ALARM;
      latch_nxt = 1'b1;
    end else begin
      if (latch_r && below_low) begin
        latch_nxt = 1'b0;
        beep_nxt  = 1'b0;
        mode_nxt  = thoc_pkg::MODE_HEATING;
        pat_nxt   = thoc_pkg::PAT_RED | thoc_pkg::PAT_HEATER;
        tone      = thoc_pkg::TONE_STOP;
      end
      if (at_tgt && !above_thr && !beep_nxt) begin
        tone     = thoc_pkg::TONE_READY;
        beep_nxt = 1'b1;
      end
      if (at_tgt) begin
        cls = thoc_pkg::MODE_DONE;
      end else if (!below_low) begin
        cls = thoc_pkg::MODE_READY;
      end
      if (cls != mode_nxt) begin
        mode_nxt = cls;
        if (latch_nxt) begin
          pat_nxt = thoc_pkg::PAT_OFF;
          tone    = thoc_pkg::TONE_STOP;
        end else begin
          case (cls)
            thoc_pkg::MODE_HEATING: begin
              pat_nxt = thoc_pkg::PAT_RED | thoc_pkg::PAT_HEATER;
              tone    = thoc_pkg::TONE_STOP;
            end
            thoc_pkg::MODE_READY: begin
              pat_nxt = thoc_pkg::PAT_GREEN | thoc_pkg::PAT_HEATER;
              tone    = thoc_pkg::TONE_STOP;
            end
            thoc_pkg::MODE_DONE: begin
              pat_nxt = thoc_pkg::PAT_GREEN | thoc_pkg::PAT_HEATER;
              tone    = thoc_pkg::TONE_DONE;
            end
            default: begin
              pat_nxt = thoc_pkg::PAT_BLUE;
              tone    = thoc_pkg::TONE_STOP;
            end
          endcase
        end
      end
      if (below_low) begin
        beep_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= thoc_pkg::MODE_IDLE;
      latch_r <= 1'b0;
      beep_r  <= 1'b0;
      pat_r   <= thoc_pkg::PAT_OFF;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      latch_r <= latch_nxt;
      beep_r  <= beep_nxt;
      pat_r   <= pat_nxt;
    end
  end

  assign res.ctrl_state     = thoc_pkg::mode_code(mode_nxt);
  assign res.heater_on      = pat_nxt[0];
  assign res.led_red        = pat_nxt[1];
  assign res.led_green      = pat_nxt[2];
  assign res.led_blue       = pat_nxt[3];
  assign res.tone_cmd       = tone;
  assign res.heater_enabled = !latch_nxt;

  a_latch_dark: assert property (@(posedge clk) disable iff (!rst_n)
    latch_r |-> (pat_r == thoc_pkg::PAT_BLUE || pat_r == thoc_pkg::PAT_OFF))
    else $error("lights on while cutout latched");

  a_shutdown_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == thoc_pkg::MODE_SHUTDOWN) |-> latch_r)
    else $error("shutdown state without latch");

  a_latch_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(latch_r) |-> (mode_r == thoc_pkg::MODE_SHUTDOWN && pat_r == thoc_pkg::PAT_BLUE))
    else $error("latch set outside overheat entry");

  a_recover_heating: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && latch_r && !latch_nxt) |=> (mode_r == thoc_pkg::MODE_HEATING))
    else $error("recovery did not land in heating");

endmodule

[hdl/thermostat_overheat_cutout_top.sv]
`timescale 1ns / 1ps

// Hysteresis thermostat with overheat cutout. One temperature sample beat is
// taken per clock unless out_tready stalls the output, and each produces one
// result beat through the input register, then the result register. The
// controller state update is a compare-and-select loop, so the rate holds with
// no gaps. Configuration writes are always accepted (cfg_ready is tied high)
// and should only be issued while no samples are in flight.

module thermostat_overheat_cutout_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [thoc_pkg::InDataW-1:0]     in_tdata,   // [11:0] temp_sample
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [2:0] ctrl_state, [3] heater_on, [4] led_red, [5] led_green, [6] led_blue,
  // [9:7] tone_cmd, [10] heater_enabled
  output logic [thoc_pkg::OutDataW-1:0]    out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [thoc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [thoc_pkg::CfgDataW-1:0]    cfg_data
);

  logic                            s1_vld_r;
  logic [thoc_pkg::SampleW-1:0]    sample_r;
  logic                            out_vld_r;
  thoc_pkg::result_t               res_r;
  thoc_pkg::result_t               res;
  thoc_pkg::cfg_t                  cfg_r;
  logic                            adv;
  logic                            step_en;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || adv;
  assign step_en   = s1_vld_r && adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_temp     <= thoc_pkg::TargetRst;
      cfg_r.hysteresis_band <= thoc_pkg::BandRst;
      cfg_r.overheat_offset <= thoc_pkg::OffsetRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        thoc_pkg::CFG_TARGET: cfg_r.target_temp     <= cfg_data;
        thoc_pkg::CFG_BAND:   cfg_r.hysteresis_band <= cfg_data[thoc_pkg::BandW-1:0];
        thoc_pkg::CFG_OFFSET: cfg_r.overheat_offset <= cfg_data[thoc_pkg::OffsetW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sample_r <= in_tdata[thoc_pkg::SampleW-1:0];
    end
    if (step_en) begin
      res_r <= res;
    end
  end

  thoc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .sample  (sample_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b00000, res_r.heater_enabled, res_r.tone_cmd, res_r.led_blue,
                       res_r.led_green, res_r.led_red, res_r.heater_on, res_r.ctrl_state};

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam logic [thoc_pkg::CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int STUCK_LIMIT = 1000;
  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 80;

  typedef struct packed {
    logic [thoc_pkg::CodeW-1:0] state;
    logic                       heater;
    logic                       red;
    logic                       green;
    logic                       blue;
    logic [thoc_pkg::ToneW-1:0] tone;
    logic                       enabled;
  } reading_t;

  typedef struct packed {
    logic     on;
    reading_t r;
  } pin_t;

  typedef struct packed {
    logic [thoc_pkg::SampleW-1:0] temp;
    logic                         pin;
    logic [thoc_pkg::CodeW-1:0]   st;
    logic [thoc_pkg::PatW-1:0]    pat;
    logic [thoc_pkg::ToneW-1:0]   tone;
    logic                         en;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [thoc_pkg::InDataW-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [thoc_pkg::OutDataW-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [thoc_pkg::CfgIdxW-1:0] cfg_index;
  logic [thoc_pkg::CfgDataW-1:0] cfg_data;

  thermostat_overheat_cutout_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // thermostat copy: registers and controller state
  logic [thoc_pkg::TargetW-1:0] p_tgt  = thoc_pkg::TargetRst;
  logic [thoc_pkg::BandW-1:0]   p_band = thoc_pkg::BandRst;
  logic [thoc_pkg::OffsetW-1:0] p_offs = thoc_pkg::OffsetRst;
  logic [thoc_pkg::CodeW-1:0]   p_mode = thoc_pkg::CODE_IDLE;
  logic                         p_latch = 1'b0;
  logic                         p_beep = 1'b0;
  logic [thoc_pkg::PatW-1:0]    p_pat = thoc_pkg::PAT_OFF;

  reading_t due_readings[$];
  pin_t     pinned[$];

  int n_samples, n_results, n_cfg, n_trips, n_recover, mismatches;
  int stuck_cycles;
  bit quiet, hold_req;

  // directed walk at reset settings: target 480, band 32, offset 80
  plan_row_t plan [0:21] = '{
    '{12'd0,   1'b1, thoc_pkg::CODE_HEATING, thoc_pkg::PAT_HEATER | thoc_pkg::PAT_RED,
      thoc_pkg::TONE_STOP, 1'b1},
    '{12'd460, 1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0},
    '{12'd480, 1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0},
    '{12'd560, 1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0},
    '{12'd561, 1'b1, thoc_pkg::CODE_SHUTDOWN, thoc_pkg::PAT_BLUE, thoc_pkg::TONE_ALARM, 1'b0},
    '{12'h7FF, 1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0},
    '{12'd450, 1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0},
    '{12'd447, 1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0},
    '{12'd500, 1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0},
    '{12'd449, 1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0},
    '{12'd480, 1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0},
    '{12'd400, 1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0},
    '{12'h800, 1'b1, thoc_pkg::CODE_HEATING, thoc_pkg::PAT_HEATER | thoc_pkg::PAT_RED,
      thoc_pkg::TONE_NONE, 1'b1},
    '{12'd520, 1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0},
    '{12'h7FF, 1'b1, thoc_pkg::CODE_SHUTDOWN, thoc_pkg::PAT_BLUE, thoc_pkg::TONE_ALARM, 1'b0},
    '{12'h800, 1'b1, thoc_pkg::CODE_HEATING, thoc_pkg::PAT_HEATER | thoc_pkg::PAT_RED,
      thoc_pkg::TONE_STOP, 1'b1},
    '{12'd448, 1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0},
    '{12'd448, 1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0},
    '{12'd561, 1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0},
    '{12'd500, 1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0},
    '{12'd500, 1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0},
    '{12'd0,   1'b0, thoc_pkg::CODE_IDLE, thoc_pkg::PAT_OFF, thoc_pkg::TONE_NONE, 1'b0}
  };

  function automatic logic [thoc_pkg::ToneW-1:0] show_lamps(logic [thoc_pkg::CodeW-1:0] st);
    logic [thoc_pkg::ToneW-1:0] tone;
    tone = thoc_pkg::TONE_STOP;
    if (p_latch) begin
      p_pat = thoc_pkg::PAT_OFF;
    end else begin
      case (st)
        thoc_pkg::CODE_HEATING: p_pat = thoc_pkg::PAT_RED | thoc_pkg::PAT_HEATER;
        thoc_pkg::CODE_READY:   p_pat = thoc_pkg::PAT_GREEN | thoc_pkg::PAT_HEATER;
        thoc_pkg::CODE_DONE: begin
          p_pat = thoc_pkg::PAT_GREEN | thoc_pkg::PAT_HEATER;
          tone = thoc_pkg::TONE_DONE;
        end
        default:      p_pat = thoc_pkg::PAT_BLUE;
      endcase
    end
    return tone;
  endfunction

  function automatic reading_t cutout_step(logic [thoc_pkg::SampleW-1:0] raw);
    int t, tg, hi, lo;
    logic [thoc_pkg::CodeW-1:0] cls;
    logic [thoc_pkg::ToneW-1:0] tone;
    reading_t r;
    t = int'($signed(raw));
    tg = int'(p_tgt);
    hi = tg + int'(p_offs);
    lo = tg - int'(p_band);
    tone = thoc_pkg::TONE_NONE;
    if (p_mode == thoc_pkg::CODE_SHUTDOWN && !p_latch) begin
      // shutdown without latch holds everything
    end else if (t > hi && !p_latch) begin
      p_mode = thoc_pkg::CODE_SHUTDOWN;
      p_pat = thoc_pkg::PAT_BLUE;
      tone = thoc_pkg::TONE_ALARM;
      p_latch = 1'b1;
      n_trips++;
    end else begin
      if (p_latch && t < lo) begin
        p_latch = 1'b0;
        p_beep = 1'b0;
        p_mode = thoc_pkg::CODE_HEATING;
        tone = show_lamps(thoc_pkg::CODE_HEATING);
        n_recover++;
      end
      if (t >= tg && t <= hi && !p_beep) begin
        tone = thoc_pkg::TONE_READY;
        p_beep = 1'b1;
      end
      if (t >= tg) cls = thoc_pkg::CODE_DONE;
      else if (t >= lo) cls = thoc_pkg::CODE_READY;
      else cls = thoc_pkg::CODE_HEATING;
      if (cls != p_mode) begin
        p_mode = cls;
        tone = show_lamps(cls);
      end
      if (t < lo) p_beep = 1'b0;
    end
    r.state = p_mode;
    r.heater = |(p_pat & thoc_pkg::PAT_HEATER);
    r.red = |(p_pat & thoc_pkg::PAT_RED);
    r.green = |(p_pat & thoc_pkg::PAT_GREEN);
    r.blue = |(p_pat & thoc_pkg::PAT_BLUE);
    r.tone = tone;
    r.enabled = !p_latch;
    return r;
  endfunction

  // mostly samples near the band edges, the rest anywhere in 12 bits
  function automatic logic [thoc_pkg::SampleW-1:0] pick_temp();
    int k, base;
    logic [thoc_pkg::SampleW-1:0] v;
    k = $urandom_range(0, 9);
    if (k < 3) base = int'(p_tgt) - int'(p_band);
    else if (k < 6) base = int'(p_tgt);
    else base = int'(p_tgt) + int'(p_offs);
    base = base + int'($urandom_range(0, 6)) - 3;
    v = base[thoc_pkg::SampleW-1:0];
    if (k == 9) v = thoc_pkg::SampleW'($urandom);
    return v;
  endfunction

  task automatic report(string what, logic [15:0] want, logic [15:0] got);
    mismatches++;
    $display("mismatch at result %0d, %s: expected %0h, got %0h", n_results, what, want, got);
  endtask

  task automatic send_temp(logic [thoc_pkg::SampleW-1:0] t, logic pin, reading_t want);
    pin_t entry;
    entry.on = pin;
    entry.r = want;
    pinned.push_back(entry);
    while (!quiet && $urandom_range(0, 99) < 11) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {{(thoc_pkg::InDataW - thoc_pkg::SampleW){1'b0}}, t};
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [thoc_pkg::CfgIdxW-1:0] idx,
                           logic [thoc_pkg::CfgDataW-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (due_readings.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // prediction on accepted beats, then check of result beats
  always @(posedge clk) begin : track
    reading_t r, w;
    pin_t p;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        case (cfg_index)
          thoc_pkg::CFG_TARGET: p_tgt = cfg_data[thoc_pkg::TargetW-1:0];
          thoc_pkg::CFG_BAND:   p_band = cfg_data[thoc_pkg::BandW-1:0];
          thoc_pkg::CFG_OFFSET: p_offs = cfg_data[thoc_pkg::OffsetW-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        n_samples++;
        r = cutout_step(in_tdata[thoc_pkg::SampleW-1:0]);
        p = pinned.pop_front();
        due_readings.push_back(p.on ? p.r : r);
      end
      if (out_tvalid && out_tready) begin
        n_results++;
        if (due_readings.size() == 0) begin
          report("result with nothing pending", '0, out_tdata);
        end else begin
          w = due_readings.pop_front();
          if (out_tdata[2:0] !== w.state)
            report("ctrl_state", 16'(w.state), 16'(out_tdata[2:0]));
          if (out_tdata[3] !== w.heater)
            report("heater_on", 16'(w.heater), 16'(out_tdata[3]));
          if (out_tdata[4] !== w.red) report("led_red", 16'(w.red), 16'(out_tdata[4]));
          if (out_tdata[5] !== w.green)
            report("led_green", 16'(w.green), 16'(out_tdata[5]));
          if (out_tdata[6] !== w.blue) report("led_blue", 16'(w.blue), 16'(out_tdata[6]));
          if (out_tdata[9:7] !== w.tone)
            report("tone_cmd", 16'(w.tone), 16'(out_tdata[9:7]));
          if (out_tdata[10] !== w.enabled)
            report("heater_enabled", 16'(w.enabled), 16'(out_tdata[10]));
          if (out_tdata[15:11] !== 5'd0) report("padding", '0, 16'(out_tdata[15:11]));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stuck_cycles = 0;
    else
      stuck_cycles = stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("no beat moved for %0d cycles", STUCK_LIMIT);
      $display("thermostat_overheat_cutout_top regression: fail");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready = 1'b0;
        repeat (60) @(negedge clk);
      end
      out_tready = quiet || ($urandom_range(0, 99) >= 11);
    end
  end

  initial begin : stim
    reading_t r;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = thoc_pkg::CFG_TARGET;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      r.state = plan[i].st;
      r.heater = |(plan[i].pat & thoc_pkg::PAT_HEATER);
      r.red = |(plan[i].pat & thoc_pkg::PAT_RED);
      r.green = |(plan[i].pat & thoc_pkg::PAT_GREEN);
      r.blue = |(plan[i].pat & thoc_pkg::PAT_BLUE);
      r.tone = plan[i].tone;
      r.enabled = plan[i].en;
      send_temp(plan[i].temp, plan[i].pin, r);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(thoc_pkg::CFG_TARGET, '0);
          write_reg(thoc_pkg::CFG_BAND, '0);
          write_reg(thoc_pkg::CFG_OFFSET, '0);
        end
        1: begin
          write_reg(thoc_pkg::CFG_TARGET, 11'h7FF);
          write_reg(thoc_pkg::CFG_BAND, 11'h7FF);
          write_reg(thoc_pkg::CFG_OFFSET, 11'h7FF);
        end
        2: begin
          write_reg(CFG_UNUSED, thoc_pkg::CfgDataW'($urandom));
          write_reg(thoc_pkg::CFG_TARGET, thoc_pkg::TargetRst);
          write_reg(thoc_pkg::CFG_BAND, thoc_pkg::CfgDataW'(thoc_pkg::BandRst));
          write_reg(thoc_pkg::CFG_OFFSET, thoc_pkg::CfgDataW'(thoc_pkg::OffsetRst));
        end
        default: begin
          write_reg(thoc_pkg::CFG_TARGET, thoc_pkg::CfgDataW'($urandom_range(0, 2047)));
          write_reg(thoc_pkg::CFG_BAND, thoc_pkg::CfgDataW'($urandom_range(0, 2047)));
          write_reg(thoc_pkg::CFG_OFFSET, thoc_pkg::CfgDataW'($urandom_range(0, 2047)));
        end
      endcase
      cfg_valid = 1'b0;
      quiet = (ph == 3);
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 5 && n == PHASE_BEATS / 2) drain();
        send_temp(pick_temp(), 1'b0, '0);
      end
    end
    quiet = 1'b0;

    in_tvalid = 1'b0;
    while (due_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d sample beats, %0d result beats, %0d register writes", n_samples, n_results,
             n_cfg);
    $display("overheat trips %0d, recoveries %0d, mismatches %0d", n_trips, n_recover,
             mismatches);
    if (mismatches == 0)
      $display("thermostat_overheat_cutout_top regression: pass");
    else
      $display("thermostat_overheat_cutout_top regression: fail");
    $finish;
  end

endmodule

[thermostat_overheat_cutout_top.f]
hdl/thoc_pkg.sv
hdl/thoc_core.sv
hdl/thermostat_overheat_cutout_top.sv
tb/testbench.sv
